[src/assert_macros.svh]
// Assertion helpers shared by the RTL. The clock is clock and the reset is reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ph2d_pkg.sv]
package ph2d_pkg;

   localparam int BIN_BITS  = 8;
   localparam int ADDR_BITS = 2 * BIN_BITS;
   localparam int OP_BITS   = 2;
   localparam int TYPE_BITS = 3;
   localparam int ELEM_BITS = 64;
   localparam int OUT_BITS  = 32;

   typedef logic [OP_BITS-1:0]   opcode_type;
   typedef logic [TYPE_BITS-1:0] elem_kind_type;
   typedef logic [BIN_BITS-1:0]  bin_type;

   localparam opcode_type OP_ADD   = 2'd0;
   localparam opcode_type OP_READ  = 2'd1;
   localparam opcode_type OP_CLEAR = 2'd2;

   localparam elem_kind_type TYPE_NONE = 3'd0;
   localparam elem_kind_type TYPE_U8   = 3'd1;
   localparam elem_kind_type TYPE_U16  = 3'd2;
   localparam elem_kind_type TYPE_U32  = 3'd3;
   localparam elem_kind_type TYPE_U64  = 3'd4;
   localparam elem_kind_type TYPE_F32  = 3'd5;
   localparam elem_kind_type TYPE_F64  = 3'd6;
   localparam elem_kind_type TYPE_RSVD = 3'd7;

   // Widest significand (f64 with hidden bit) and the product with 255.
   localparam int MANT_BITS  = 53;
   localparam int QNUM_BITS  = MANT_BITS + 8;
   localparam int SHIFT_BITS = 12;

   // bias + fraction bits + exponent range, per float format.
   localparam logic [SHIFT_BITS-1:0] F32_SCALE = 12'd278;
   localparam logic [SHIFT_BITS-1:0] F64_SCALE = 12'd2099;

endpackage

[src/ph2d_if.sv]
interface ph2d_req_if;
   logic                             valid;
   logic                             ready;
   ph2d_pkg::opcode_type             opcode;
   logic [ph2d_pkg::ELEM_BITS-1:0]   element_value;
   logic                             first_in_run;
   ph2d_pkg::bin_type                read_row;
   ph2d_pkg::bin_type                read_col;

   modport source (output valid, opcode, element_value, first_in_run, read_row, read_col,
                   input ready);
   modport sink   (input valid, opcode, element_value, first_in_run, read_row, read_col,
                   output ready);
endinterface

interface ph2d_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ph2d_pkg::OUT_BITS-1:0]   pair_count;
   ph2d_pkg::bin_type               row_echo;
   ph2d_pkg::bin_type               col_echo;

   modport source (output valid, pair_count, row_echo, col_echo, input ready);
   modport sink   (input valid, pair_count, row_echo, col_echo, output ready);
endinterface

[src/pair_histogram_2d.sv]
// Pair histogram over a 256 x 256 table of saturating counters.
// req_ch carries one item per handshake: add an element, read one count, or
// clear all counts. Only a read produces an item on rsp_ch (count, row, column).
// csr_we/csr_wdata set the element type; write it only while the block is idle.
// The counters live in one 65536-entry synchronous memory, updated by
// read-modify-write one item at a time; the block takes a new item only once the last is done:
//    add, no pair formed        quantize, bin select
//    add, pair counted          quantize, bin select, read, write
//    read                       memory read, then the output register once it is free
//    clear                      all 65536 entries, one memory entry zeroed per cycle
// Reset starts the same clearing sweep over all 65536 entries; req_ch.ready stays low until
// it is done. The element type returns to u8 and the run history is dropped.
// The result sits in an output register: further adds and clears proceed while
// rsp_ch is stalled, and a later read waits only until that register frees up.
module pair_histogram_2d #(
   parameter int COUNT_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   ph2d_req_if.sink                         req_ch,
   ph2d_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [ph2d_pkg::TYPE_BITS-1:0]   csr_wdata
);

`include "assert_macros.svh"

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_QUANT   = 3'd1;
   localparam logic [2:0] ST_BIN     = 3'd2;
   localparam logic [2:0] ST_PAIR_RD = 3'd3;
   localparam logic [2:0] ST_PAIR_WR = 3'd4;
   localparam logic [2:0] ST_CNT_RD  = 3'd5;
   localparam logic [2:0] ST_CNT_RSP = 3'd6;
   localparam logic [2:0] ST_CLEAR   = 3'd7;

   localparam int DEPTH = 1 << ph2d_pkg::ADDR_BITS;
   localparam int QB    = ph2d_pkg::QNUM_BITS;
   localparam int MB    = ph2d_pkg::MANT_BITS;

   typedef logic [COUNT_BITS-1:0]          count_type;
   typedef logic [ph2d_pkg::ADDR_BITS-1:0] addr_type;

   // Counter store.
   count_type pair_counts_mem [DEPTH];
   count_type rd_data_ff;
   logic      mem_we;
   addr_type  mem_waddr;
   count_type mem_wdata;
   logic      mem_re;
   addr_type  mem_raddr;

   logic [2:0]                        state_ff, state_in;
   addr_type                          clr_idx_ff, clr_idx_in;
   ph2d_pkg::elem_kind_type           type_ff, type_in;
   logic [ph2d_pkg::ELEM_BITS-1:0]    elem_ff, elem_in;
   logic                              first_ff, first_in;
   ph2d_pkg::bin_type                 row_ff, row_in;
   ph2d_pkg::bin_type                 col_ff, col_in;
   ph2d_pkg::bin_type                 prev_ff, prev_in;
   logic                              have_ff, have_in;
   addr_type                          addr_ff, addr_in;

   // Quantizer stage registers.
   ph2d_pkg::bin_type                 ibin_ff, ibin_in;
   logic                              is_float_ff, is_float_in;
   logic [QB-1:0]                     qnum_ff, qnum_in;
   logic [ph2d_pkg::SHIFT_BITS-1:0]   shift_ff, shift_in;
   logic                              neg_ff, neg_in;
   logic                              special_ff, special_in;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ph2d_pkg::OUT_BITS-1:0]     count_ff, count_in;
   ph2d_pkg::bin_type                 recho_ff, recho_in;
   ph2d_pkg::bin_type                 cecho_ff, cecho_in;

   logic req_take;
   logic rsp_free;
   logic type_ok;

   // Integer quantization: the quotient by 0x0101.. is the top byte, or one less
   // when the value lies below that byte repeated across the word.
   ph2d_pkg::bin_type t16, t32, t64, i16, i32, i64, ibin_sel;
   logic [7:0]                      e32;
   logic [10:0]                     e64;
   logic [MB-1:0]                   mant;
   logic [ph2d_pkg::SHIFT_BITS-1:0] ep32, ep64;
   logic                            is64;

   // Float bin from the registered product.
   logic                            big_shift;
   logic [5:0]                      sh;
   logic [QB-1:0]                   shifted, frac_mask;
   logic                            frac;
   logic [8:0]                      qi;
   logic [8:0]                      v_pos, v_neg, v_negf;
   ph2d_pkg::bin_type               fbin, bin_cur;
   logic [63:0]                     rd_wide;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign type_ok      = (type_ff != ph2d_pkg::TYPE_NONE) && (type_ff != ph2d_pkg::TYPE_RSVD);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pair_count = count_ff;
   assign rsp_ch.row_echo   = recho_ff;
   assign rsp_ch.col_echo   = cecho_ff;

   always_comb begin
      t16 = elem_ff[15:8];
      t32 = elem_ff[31:24];
      t64 = elem_ff[63:56];
      i16 = ({2{t16}} <= elem_ff[15:0]) ? t16 : t16 - 8'd1;
      i32 = ({4{t32}} <= elem_ff[31:0]) ? t32 : t32 - 8'd1;
      i64 = ({8{t64}} <= elem_ff)       ? t64 : t64 - 8'd1;
      case (type_ff)
         ph2d_pkg::TYPE_U8:  ibin_sel = elem_ff[7:0];
         ph2d_pkg::TYPE_U16: ibin_sel = i16;
         ph2d_pkg::TYPE_U32: ibin_sel = i32;
         ph2d_pkg::TYPE_U64: ibin_sel = i64;
         default:            ibin_sel = '0;
      endcase

      is64 = (type_ff == ph2d_pkg::TYPE_F64);
      e32  = elem_ff[30:23];
      e64  = elem_ff[62:52];
      ep32 = (e32 == '0) ? 12'd1 : {4'd0, e32};
      ep64 = (e64 == '0) ? 12'd1 : {1'b0, e64};
      if (is64) begin
         mant = {e64 != '0, elem_ff[51:0]};
      end else begin
         mant = MB'({e32 != '0, elem_ff[22:0]});
      end
   end

   always_comb begin
      big_shift = (shift_ff >= ph2d_pkg::SHIFT_BITS'(QB));
      sh        = shift_ff[5:0];
      shifted   = qnum_ff >> sh;
      frac_mask = ~({QB{1'b1}} << sh);
      if (big_shift) begin
         frac = (qnum_ff != '0);
         qi   = 9'd0;
      end else begin
         frac = ((qnum_ff & frac_mask) != '0);
         qi   = (shifted > QB'(255)) ? 9'd255 : {1'b0, shifted[7:0]};
      end
      v_pos  = 9'd255 + qi;
      v_neg  = 9'd255 - qi;
      v_negf = 9'd254 - qi;
      if (special_ff) begin
         fbin = neg_ff ? 8'd0 : 8'd255;
      end else if (!neg_ff) begin
         fbin = v_pos[8:1];
      end else if (!frac) begin
         fbin = v_neg[8:1];
      end else begin
         fbin = (qi >= 9'd254) ? 8'd0 : v_negf[8:1];
      end
      bin_cur = is_float_ff ? fbin : ibin_ff;
      rd_wide = 64'(rd_data_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      type_in      = csr_we ? csr_wdata : type_ff;
      elem_in      = elem_ff;
      first_in     = first_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      prev_in      = prev_ff;
      have_in      = have_ff;
      addr_in      = addr_ff;
      ibin_in      = ibin_ff;
      is_float_in  = is_float_ff;
      qnum_in      = qnum_ff;
      shift_in     = shift_ff;
      neg_in       = neg_ff;
      special_in   = special_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      count_in     = count_ff;
      recho_in     = recho_ff;
      cecho_in     = cecho_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               elem_in  = req_ch.element_value;
               first_in = req_ch.first_in_run;
               row_in   = req_ch.read_row;
               col_in   = req_ch.read_col;
               case (req_ch.opcode)
                  ph2d_pkg::OP_ADD:   state_in = type_ok ? ST_QUANT : ST_IDLE;
                  ph2d_pkg::OP_READ:  state_in = ST_CNT_RD;
                  ph2d_pkg::OP_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_idx_in = '0;
                  end
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_QUANT: begin
            ibin_in     = ibin_sel;
            is_float_in = (type_ff == ph2d_pkg::TYPE_F32) || is64;
            qnum_in     = {mant, 8'd0} - QB'(mant);
            shift_in    = is64 ? ph2d_pkg::F64_SCALE - ep64 : ph2d_pkg::F32_SCALE - ep32;
            neg_in      = is64 ? elem_ff[63] : elem_ff[31];
            special_in  = is64 ? (e64 == '1) : (e32 == '1);
            state_in    = ST_BIN;
         end
         ST_BIN: begin
            addr_in  = {prev_ff, bin_cur};
            prev_in  = bin_cur;
            have_in  = 1'b1;
            state_in = (!first_ff && have_ff) ? ST_PAIR_RD : ST_IDLE;
         end
         ST_PAIR_RD: begin
            mem_re   = 1'b1;
            state_in = ST_PAIR_WR;
         end
         ST_PAIR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + count_type'(1);
            state_in  = ST_IDLE;
         end
         ST_CNT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {row_ff, col_ff};
            state_in  = ST_CNT_RSP;
         end
         ST_CNT_RSP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               count_in     = (rd_wide > 64'hffff_ffff) ? '1 : rd_wide[31:0];
               recho_in     = row_ff;
               cecho_in     = col_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + addr_type'(1);
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pair_counts_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= pair_counts_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         type_ff      <= ph2d_pkg::TYPE_U8;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         type_ff      <= type_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff     <= elem_in;
      first_ff    <= first_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      addr_ff     <= addr_in;
      ibin_ff     <= ibin_in;
      is_float_ff <= is_float_in;
      qnum_ff     <= qnum_in;
      shift_ff    <= shift_in;
      neg_ff      <= neg_in;
      special_ff  <= special_in;
      count_ff    <= count_in;
      recho_ff    <= recho_in;
      cecho_ff    <= cecho_in;
   end

   // A counter update always finishes its write before the next item is taken.
   `ASSERT_NEXT(a_pair_wr_done, state_ff == ST_PAIR_WR, state_ff == ST_IDLE, "pair write did not return to idle")

   // A new result appears only out of the read-response step.
   `ASSERT_ALWAYS(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CNT_RSP, "result raised outside a read")

   // The clearing sweep advances by one entry per cycle until it wraps.
   `ASSERT_NEXT(a_clear_step, state_ff == ST_CLEAR && clr_idx_ff != '1, clr_idx_ff == $past(clr_idx_ff) + addr_type'(1) && state_ff == ST_CLEAR, "clear sweep skipped an entry")

   // Once an element has been seen, the run history is never lost.
   `ASSERT_NEXT(a_have_sticky, have_ff, have_ff, "previous element flag dropped")

endmodule

[bench/tb_pair_histogram_2d.sv]
`timescale 1ns / 100ps

module tb_pair_histogram_2d;

   localparam time        HALF_PERIOD = 5ns;
   localparam int         STALL_LIMIT = 200000;
   localparam int         CLEAR_SETTLE = 65545;
   localparam int         ITEM_SETTLE = 8;
   localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;
   localparam ph2d_pkg::opcode_type OP_UNUSED = 2'd3;

   typedef struct {
      logic [ph2d_pkg::OUT_BITS-1:0] count;
      ph2d_pkg::bin_type             row;
      ph2d_pkg::bin_type             col;
   } pair_read_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [ph2d_pkg::TYPE_BITS-1:0] csr_wdata;

   ph2d_req_if req_ch ();
   ph2d_rsp_if rsp_ch ();

   pair_histogram_2d #(.COUNT_BITS(32)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow of the histogram state.
   logic [31:0]             pair_tally [bit [15:0]];
   ph2d_pkg::bin_type       prev_bin;
   bit                      have_prev;
   ph2d_pkg::elem_kind_type active_kind;
   bit                      clear_in_flight;
   bit [15:0]               recent_cells [$];
   pair_read_type           expected_reads [$];
   pair_read_type           want_read;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int quiet_cycles;
   int error_count;
   int add_count;
   int read_count;
   int clear_count;
   int checked_count;

   function automatic ph2d_pkg::bin_type float_bin(logic [63:0] bits, bit is_double);
      int          mbits;
      int          ebits;
      int          scale;
      int          ep;
      int          shift;
      logic [63:0] expo;
      logic [63:0] emax;
      logic [63:0] mant;
      logic [63:0] qn;
      logic [63:0] qi;
      logic [63:0] r;
      bit          neg;
      bit          frac;
      mbits = is_double ? 52 : 23;
      ebits = is_double ? 11 : 8;
      scale = is_double ? int'(ph2d_pkg::F64_SCALE) : int'(ph2d_pkg::F32_SCALE);
      neg   = bits[mbits + ebits];
      emax  = (64'd1 << ebits) - 64'd1;
      expo  = (bits >> mbits) & emax;
      mant  = bits & ((64'd1 << mbits) - 64'd1);
      if (expo == emax) return neg ? 8'd0 : 8'd255;
      if (expo != 0) mant = mant | (64'd1 << mbits);
      ep = (expo == 0) ? 1 : int'(expo);
      // The scaled value x / 2^emax is mant * 2^(ep - scale); fold in the 255.
      qn    = mant * 64'd255;
      shift = scale - ep;
      if (shift >= 64) begin
         qi   = 64'd0;
         frac = (qn != 0);
      end else begin
         qi   = qn >> shift;
         frac = ((qn & ((64'd1 << shift) - 64'd1)) != 0);
      end
      if (qi > 64'd255) qi = 64'd255;
      if (!neg) begin
         r = (64'd255 + qi) >> 1;
      end else if (!frac) begin
         r = (64'd255 - qi) >> 1;
      end else begin
         r = (qi >= 64'd254) ? 64'd0 : ((64'd254 - qi) >> 1);
      end
      if (r > 64'd255) r = 64'd255;
      return r[7:0];
   endfunction

   function automatic bit quantize_element(logic [63:0] v, ph2d_pkg::elem_kind_type kind,
                                           output ph2d_pkg::bin_type b);
      b = '0;
      case (kind)
         ph2d_pkg::TYPE_U8:  b = v[7:0];
         ph2d_pkg::TYPE_U16: b = ph2d_pkg::bin_type'(v[15:0] / 16'd257);
         ph2d_pkg::TYPE_U32: b = ph2d_pkg::bin_type'(v[31:0] / 32'h0101_0101);
         ph2d_pkg::TYPE_U64: b = ph2d_pkg::bin_type'(v / 64'h0101_0101_0101_0101);
         ph2d_pkg::TYPE_F32: b = float_bin({32'd0, v[31:0]}, 1'b0);
         ph2d_pkg::TYPE_F64: b = float_bin(v, 1'b1);
         default:            return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic void apply_request(ph2d_pkg::opcode_type op, logic [63:0] val,
                                         logic run_start,
                                         ph2d_pkg::bin_type row, ph2d_pkg::bin_type col);
      ph2d_pkg::bin_type b;
      bit [15:0]         slot;
      pair_read_type     r;
      case (op)
         ph2d_pkg::OP_ADD: begin
            if (quantize_element(val, active_kind, b)) begin
               if (!run_start && have_prev) begin
                  slot = {prev_bin, b};
                  if (!pair_tally.exists(slot)) pair_tally[slot] = 32'd0;
                  if (pair_tally[slot] != COUNT_MAX) pair_tally[slot] = pair_tally[slot] + 1;
                  recent_cells.push_back(slot);
                  if (recent_cells.size() > 64) recent_cells.delete(0);
               end
               prev_bin  = b;
               have_prev = 1'b1;
               add_count++;
            end
         end
         ph2d_pkg::OP_READ: begin
            slot    = {row, col};
            r.count = pair_tally.exists(slot) ? pair_tally[slot] : 32'd0;
            r.row   = row;
            r.col   = col;
            expected_reads.push_back(r);
            // A read is taken only once any earlier clear has finished.
            clear_in_flight = 1'b0;
            read_count++;
         end
         ph2d_pkg::OP_CLEAR: begin
            pair_tally.delete();
            clear_in_flight = 1'b1;
            clear_count++;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [63:0] raw_element(ph2d_pkg::elem_kind_type kind);
      logic [63:0] v;
      logic [63:0] mask;
      int          pick;
      v    = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      case (kind)
         ph2d_pkg::TYPE_F32: begin
            if (pick < 15) v[30:23] = 8'hff;
            else if (pick < 30) v[30:23] = 8'h00;
            else if (pick < 70) v[30:23] = 8'($urandom_range(254, 235));
            if ($urandom_range(4) == 0) v[22:0] = '0;
         end
         ph2d_pkg::TYPE_F64: begin
            if (pick < 15) v[62:52] = 11'h7ff;
            else if (pick < 30) v[62:52] = 11'h000;
            else if (pick < 70) v[62:52] = 11'($urandom_range(2046, 2025));
            if ($urandom_range(4) == 0) v[51:0] = '0;
         end
         default: begin
            case (kind)
               ph2d_pkg::TYPE_U16: mask = 64'hffff;
               ph2d_pkg::TYPE_U32: mask = 64'hffff_ffff;
               ph2d_pkg::TYPE_U64: mask = '1;
               default:            mask = 64'hff;
            endcase
            if (pick < 12) v = v & ~mask;
            else if (pick < 24) v = v | mask;
         end
      endcase
      return v;
   endfunction

   function automatic void pick_read_cell(output ph2d_pkg::bin_type row,
                                          output ph2d_pkg::bin_type col);
      bit [15:0] slot;
      if (recent_cells.size() != 0 && $urandom_range(99) < 75)
         slot = recent_cells[$urandom_range(recent_cells.size() - 1)];
      else
         slot = 16'($urandom);
      row = slot[15:8];
      col = slot[7:0];
   endfunction

   function automatic void set_flow(int mode);
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 76;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 76;
         end
         default: begin
            send_idle_pct  = 32;
            recv_stall_pct = 32;
         end
      endcase
   endfunction

   // Offers one item and returns at the edge where it is accepted, with valid
   // still high so that a following call can present the next item at once.
   task automatic send_item(ph2d_pkg::opcode_type op, logic [63:0] val, logic run_start,
                            ph2d_pkg::bin_type row, ph2d_pkg::bin_type col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.element_value <= val;
      req_ch.first_in_run  <= run_start;
      req_ch.read_row      <= row;
      req_ch.read_col      <= col;
      do @(posedge clock); while (!req_ch.ready);
      apply_request(op, val, run_start, row, col);
   endtask

   task automatic set_element_type(ph2d_pkg::elem_kind_type kind);
      req_ch.valid <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (clear_in_flight ? CLEAR_SETTLE : ITEM_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= kind;
      @(posedge clock);
      csr_we          <= 1'b0;
      active_kind     = kind;
      clear_in_flight = 1'b0;
   endtask

   task automatic test_u8_edges();
      set_flow(0);
      // The first add after reset has no earlier element to pair with.
      send_item(ph2d_pkg::OP_ADD, 64'hffff_ffff_ffff_ff00, 1'b0, 8'hff, 8'hff);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_0000_00ff, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_0000_0080, 1'b1, 8'h00, 8'h00);
      send_item(OP_UNUSED, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff, 8'hff);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_0000_007f, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'h00, 8'hff);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'h80, 8'h7f);
   endtask

   task automatic test_unsigned_types();
      set_flow(1);
      set_element_type(ph2d_pkg::TYPE_U16);
      send_item(ph2d_pkg::OP_ADD, 64'hdead_beef_cafe_ffff, 1'b0, 8'h00, 8'h00);
      set_element_type(ph2d_pkg::TYPE_U32);
      send_item(ph2d_pkg::OP_ADD, 64'hffff_ffff_0000_0000, 1'b0, 8'h00, 8'h00);
      set_element_type(ph2d_pkg::TYPE_U64);
      send_item(ph2d_pkg::OP_ADD, 64'hffff_ffff_ffff_ffff, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h0101_0101_0101_0100, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'hff, 8'h00);
   endtask

   task automatic test_float_types();
      set_flow(2);
      set_element_type(ph2d_pkg::TYPE_F32);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_7f80_0000, 1'b1, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'hffff_ffff_ff80_0000, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h1234_5678_7fc0_0001, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_8000_0000, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_7f7f_ffff, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h0000_0000_0000_0001, 1'b0, 8'h00, 8'h00);
      set_element_type(ph2d_pkg::TYPE_F64);
      send_item(ph2d_pkg::OP_ADD, 64'hfff0_0000_0000_0000, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h7fef_ffff_ffff_ffff, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h8000_0000_0000_0001, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_ADD, 64'h7ff8_0000_0000_0000, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'hff, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'h7f, 8'hfe);
   endtask

   task automatic test_clear_keeps_run();
      set_flow(3);
      set_element_type(ph2d_pkg::TYPE_U8);
      send_item(ph2d_pkg::OP_CLEAR, 64'h0, 1'b0, 8'h00, 8'h00);
      // The element before the clear still opens a pair.
      send_item(ph2d_pkg::OP_ADD, 64'h0, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'hff, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'h00, 8'hff);
   endtask

   task automatic test_ignored_types();
      set_flow(0);
      set_element_type(ph2d_pkg::TYPE_NONE);
      send_item(ph2d_pkg::OP_ADD, 64'h42, 1'b0, 8'h00, 8'h00);
      set_element_type(ph2d_pkg::TYPE_RSVD);
      send_item(ph2d_pkg::OP_ADD, 64'hff, 1'b0, 8'h00, 8'h00);
      set_element_type(ph2d_pkg::TYPE_U8);
      send_item(ph2d_pkg::OP_ADD, 64'h11, 1'b0, 8'h00, 8'h00);
      send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, 8'h00, 8'h11);
   endtask

   task automatic test_result_backpressure();
      ph2d_pkg::bin_type r;
      ph2d_pkg::bin_type c;
      set_flow(0);
      hold_left = 300;
      for (int i = 0; i < 20; i++) begin
         if (i % 2 == 0) begin
            pick_read_cell(r, c);
            send_item(ph2d_pkg::OP_READ, {$urandom(), $urandom()}, 1'($urandom), r, c);
         end else begin
            send_item(ph2d_pkg::OP_ADD, raw_element(active_kind), 1'b0,
                      8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      ph2d_pkg::elem_kind_type phase_kind [16];
      logic [63:0]             hot [4];
      logic [63:0]             v;
      ph2d_pkg::bin_type       r;
      ph2d_pkg::bin_type       c;
      bit                      live;
      int                      target;
      int                      counted;
      int                      pick;
      int                      clear_at;
      phase_kind = '{ph2d_pkg::TYPE_U8, ph2d_pkg::TYPE_F64, ph2d_pkg::TYPE_U16,
                     ph2d_pkg::TYPE_NONE, ph2d_pkg::TYPE_U32, ph2d_pkg::TYPE_F32,
                     ph2d_pkg::TYPE_U64, ph2d_pkg::TYPE_RSVD, ph2d_pkg::TYPE_F64,
                     ph2d_pkg::TYPE_U8, ph2d_pkg::TYPE_F32, ph2d_pkg::TYPE_U16,
                     ph2d_pkg::TYPE_U64, ph2d_pkg::TYPE_U32, ph2d_pkg::TYPE_F64,
                     ph2d_pkg::TYPE_F32};
      for (int p = 0; p < 16; p++) begin
         set_flow(p % 4);
         set_element_type(phase_kind[p]);
         foreach (hot[h]) hot[h] = raw_element(phase_kind[p]);
         live     = !(phase_kind[p] == ph2d_pkg::TYPE_NONE ||
                      phase_kind[p] == ph2d_pkg::TYPE_RSVD);
         target   = live ? 96 : 30;
         clear_at = (p % 4 == 2) ? $urandom_range(target - 1) : -1;
         counted  = 0;
         while (counted < target) begin
            pick = $urandom_range(99);
            r    = 8'($urandom);
            c    = 8'($urandom);
            if (counted == clear_at) begin
               send_item(ph2d_pkg::OP_CLEAR, {$urandom(), $urandom()}, 1'($urandom), r, c);
               clear_at = -1;
               counted++;
            end else if (pick < 55) begin
               // Runs of elements drawn often from a small pool, so that
               // the same cells are hit again and again.
               v = ($urandom_range(99) < 40) ? hot[$urandom_range(3)]
                                             : raw_element(phase_kind[p]);
               send_item(ph2d_pkg::OP_ADD, v, $urandom_range(99) < 8, r, c);
               if (live) counted++;
            end else if (pick < 90) begin
               pick_read_cell(r, c);
               send_item(ph2d_pkg::OP_READ, {$urandom(), $urandom()}, 1'($urandom), r, c);
               counted++;
            end else if (pick < 95) begin
               send_item(OP_UNUSED, {$urandom(), $urandom()}, 1'($urandom), r, c);
            end else begin
               send_item(ph2d_pkg::OP_ADD, {$urandom(), $urandom()}, 1'($urandom), r, c);
               if (live) counted++;
            end
         end
         pick_read_cell(r, c);
         send_item(ph2d_pkg::OP_READ, 64'h0, 1'b0, r, c);
      end
   endtask

   // Result side: random stalls, the long hold-off, and the comparison.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected result: expected none, got count %0d at (%0d,%0d)",
                     $time, rsp_ch.pair_count, rsp_ch.row_echo, rsp_ch.col_echo);
            error_count++;
         end else begin
            want_read = expected_reads.pop_front();
            checked_count++;
            if (rsp_ch.pair_count !== want_read.count) begin
               $display("%0t: pair_count mismatch: expected %0d, got %0d", $time,
                        want_read.count, rsp_ch.pair_count);
               error_count++;
            end
            if (rsp_ch.row_echo !== want_read.row) begin
               $display("%0t: row_echo mismatch: expected %0d, got %0d", $time,
                        want_read.row, rsp_ch.row_echo);
               error_count++;
            end
            if (rsp_ch.col_echo !== want_read.col) begin
               $display("%0t: col_echo mismatch: expected %0d, got %0d", $time,
                        want_read.col, rsp_ch.col_echo);
               error_count++;
            end
         end
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.opcode        = ph2d_pkg::OP_ADD;
      req_ch.element_value = '0;
      req_ch.first_in_run  = 1'b0;
      req_ch.read_row      = '0;
      req_ch.read_col      = '0;
      rsp_ch.ready         = 1'b0;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      prev_bin             = '0;
      have_prev            = 1'b0;
      active_kind          = ph2d_pkg::TYPE_U8;
      clear_in_flight      = 1'b0;
      hold_left            = 0;
      quiet_cycles         = 0;
      error_count          = 0;
      add_count            = 0;
      read_count           = 0;
      clear_count          = 0;
      checked_count        = 0;
      set_flow(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_u8_edges();
      test_unsigned_types();
      test_float_types();
      test_clear_keeps_run();
      test_ignored_types();
      test_result_backpressure();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (clear_in_flight ? CLEAR_SETTLE : 2 * ITEM_SETTLE) @(posedge clock);

      $display("tb: %0d adds, %0d reads and %0d clears over all element type codes,",
               add_count, read_count, clear_count);
      $display("tb: four flow-control mixes and a long result hold-off; %0d counts checked",
               checked_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
